// ===== src/fwps_pkg.sv =====
// Package with the shared widths, register indexes and types of the flow scheduler.
`timescale 1ns / 1ps

package fwps_pkg;

  // Width of each service byte counter.
  localparam int unsigned CntW = 32;
  // Width of a head length field.
  localparam int unsigned LenW = 32;
  // Width used for the spread compare against the starvation limit.
  localparam int unsigned CmpW = (CntW > 32) ? CntW : 32;
  // Width of the configuration register index.
  localparam int unsigned CfgIdxW = 8;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegReservedMode   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegStarvLimit     = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegBulkShift      = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegStandardShift  = CfgIdxW'(3);

  // Flow codes.
  localparam logic [1:0] FlowBulk     = 2'd0;
  localparam logic [1:0] FlowStandard = 2'd1;
  localparam logic [1:0] FlowUrgent   = 2'd2;

  // Current configuration.
  typedef struct packed {
    logic        reserved_mode;
    logic [31:0] starvation_limit;
    logic [4:0]  bulk_weight_shift;
    logic [4:0]  standard_weight_shift;
  } cfg_t;

  // One request beat.
  typedef struct packed {
    logic [2:0]      queue_ready;
    logic [LenW-1:0] bulk_head_length;
    logic [LenW-1:0] standard_head_length;
  } req_t;

  // One grant beat.
  typedef struct packed {
    logic       grant_valid;
    logic [1:0] granted_flow;
    logic       counters_cleared;
  } grant_t;

endpackage

// ===== src/fwps_cfg.sv =====
// Configuration register file of the flow scheduler.
`timescale 1ns / 1ps

module fwps_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [fwps_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  output fwps_pkg::cfg_t               cfg_o
);
  import fwps_pkg::*;

  cfg_t cfg_q;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reserved_mode         <= 1'b0;
      cfg_q.starvation_limit      <= 32'd1000000;
      cfg_q.bulk_weight_shift     <= 5'd0;
      cfg_q.standard_weight_shift <= 5'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegReservedMode:  cfg_q.reserved_mode         <= cfg_data_i[0];
        RegStarvLimit:    cfg_q.starvation_limit      <= cfg_data_i;
        RegBulkShift:     cfg_q.bulk_weight_shift     <= cfg_data_i[4:0];
        RegStandardShift: cfg_q.standard_weight_shift <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/fwps_sched.sv =====
// Grant decision and service byte counters of the flow scheduler.
`timescale 1ns / 1ps

module fwps_sched (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fwps_pkg::cfg_t   cfg_i,
  input  fwps_pkg::req_t   req_i,
  input  logic             commit_i,
  output fwps_pkg::grant_t grant_o
);
  import fwps_pkg::*;

  logic [CntW-1:0] bulk_cnt_q, bulk_cnt_d;
  logic [CntW-1:0] std_cnt_q, std_cnt_d;
  logic [CntW-1:0] bulk_w, std_w, sum, new_bulk, new_std, new_bulk_w, new_std_w, spread;
  logic            pick_std, account, clear;
  grant_t          grant;

  // Weighted counters before this beat.
  assign bulk_w = bulk_cnt_q >> cfg_i.bulk_weight_shift;
  assign std_w  = std_cnt_q >> cfg_i.standard_weight_shift;

  // Weighted pick between bulk and standard; ties go to bulk.
  assign pick_std = (&req_i.queue_ready[1:0]) ? (std_w < bulk_w) : !req_i.queue_ready[0];
  assign account  = cfg_i.reserved_mode && !req_i.queue_ready[2] && (|req_i.queue_ready[1:0]);

  // Add the winner's head length, wrapping at the counter width.
  assign sum = pick_std ? (std_cnt_q + CntW'(req_i.standard_head_length))
                        : (bulk_cnt_q + CntW'(req_i.bulk_head_length));
  assign new_bulk = pick_std ? bulk_cnt_q : sum;
  assign new_std  = pick_std ? sum : std_cnt_q;

  // Spread of the updated weighted counters against the limit.
  assign new_bulk_w = new_bulk >> cfg_i.bulk_weight_shift;
  assign new_std_w  = new_std >> cfg_i.standard_weight_shift;
  assign spread = (new_bulk_w > new_std_w) ? (new_bulk_w - new_std_w)
                                           : (new_std_w - new_bulk_w);
  assign clear = CmpW'(spread) > CmpW'(cfg_i.starvation_limit);

  // Grant fields.
  always_comb begin
    grant.grant_valid      = |req_i.queue_ready;
    grant.counters_cleared = account && clear;
    if (req_i.queue_ready[2]) begin
      grant.granted_flow = FlowUrgent;
    end else if (account) begin
      grant.granted_flow = pick_std ? FlowStandard : FlowBulk;
    end else if (req_i.queue_ready[1]) begin
      grant.granted_flow = FlowStandard;
    end else begin
      grant.granted_flow = FlowBulk;
    end
  end

  // Counter update when the beat moves to the result register.
  always_comb begin
    bulk_cnt_d = bulk_cnt_q;
    std_cnt_d  = std_cnt_q;
    if (commit_i && account) begin
      bulk_cnt_d = clear ? '0 : new_bulk;
      std_cnt_d  = clear ? '0 : new_std;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bulk_cnt_q <= '0;
      std_cnt_q  <= '0;
    end else begin
      bulk_cnt_q <= bulk_cnt_d;
      std_cnt_q  <= std_cnt_d;
    end
  end

  assign grant_o = grant;

endmodule

// ===== src/flow_weighted_priority_scheduler.sv =====
// Top level of the flow weighted priority scheduler.
`timescale 1ns / 1ps

// Grants one of three flows (bulk, standard, urgent) per request beat. Strict
// mode grants the highest non-empty flow; reserved mode grants urgent first and
// otherwise the bulk or standard flow with the smaller weighted byte counter,
// charging the granted head length and clearing both counters when their
// weighted spread exceeds the starvation limit. A request is held in the input
// register, then decided and counted as it moves to the output register that
// holds its grant, so one beat is accepted every cycle unless grants stall.
// The counter add and spread compare form the loop that sets this rate.
// Configuration writes are taken every cycle and must be made while idle.
module flow_weighted_priority_scheduler (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request stream.
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // tdata: bulk_head_length[31:0], standard_head_length[63:32]
  input  logic [63:0]                  s_axis_tdata_i,
  // tuser: queue_ready[2:0]
  input  logic [2:0]                   s_axis_tuser_i,
  // Grant stream.
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // tdata: grant_valid[0], granted_flow[2:1], counters_cleared[3], zero[7:4]
  output logic [7:0]                   m_axis_tdata_o,
  // Configuration writes.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [fwps_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i
);
  import fwps_pkg::*;

  cfg_t   cfg;
  req_t   req_q;
  grant_t grant, grant_q;
  logic   in_valid_q, out_valid_q, advance;

  fwps_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The registered request moves on when the result register is free or drains.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  fwps_sched u_sched (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .req_i   (req_q),
    .commit_i(advance),
    .grant_o (grant)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      req_q.queue_ready          <= s_axis_tuser_i;
      req_q.bulk_head_length     <= s_axis_tdata_i[31:0];
      req_q.standard_head_length <= s_axis_tdata_i[63:32];
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      grant_q <= grant;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, grant_q.counters_cleared, grant_q.granted_flow,
                            grant_q.grant_valid};

endmodule

// ===== sim/fwps_checker.sv =====
// Checker that predicts and compares the grant stream of the flow scheduler.
`timescale 1ns / 1ps

module fwps_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request stream as seen at the block's slave side.
  input  logic                         req_valid_i,
  input  logic                         req_ready_i,
  input  logic [63:0]                  req_data_i,
  input  logic [2:0]                   req_user_i,
  // Grant stream as seen at the block's master side.
  input  logic                         grant_valid_i,
  input  logic                         grant_ready_i,
  input  logic [7:0]                   grant_data_i,
  // Configuration write channel.
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [fwps_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  // Status handed to the testbench top.
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           grant_count_o,
  output int                           clear_count_o
);
  import fwps_pkg::*;

  // Shadow copy of the configuration and the two service byte counters.
  cfg_t            regs;
  logic [CntW-1:0] bulk_bytes;
  logic [CntW-1:0] standard_bytes;
  grant_t          expected_grants[$];
  int              fails;
  int              grants;
  int              clears;

  // Print one mismatch line and count it.
  task automatic report(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    fails++;
  endtask

  // Decide the grant for one request and update the byte counters.
  function automatic grant_t schedule_request(input logic [2:0]      rdy,
                                              input logic [LenW-1:0] bulk_len,
                                              input logic [LenW-1:0] std_len);
    grant_t          g;
    logic            pick_std;
    logic [CntW-1:0] wb;
    logic [CntW-1:0] ws;
    logic [CntW-1:0] hi;
    logic [CntW-1:0] lo;
    g = '0;
    if (rdy[2]) begin
      // Urgent wins in both modes and is never charged.
      g.grant_valid  = 1'b1;
      g.granted_flow = FlowUrgent;
    end else if (!regs.reserved_mode) begin
      if (rdy[1]) begin
        g.grant_valid  = 1'b1;
        g.granted_flow = FlowStandard;
      end else if (rdy[0]) begin
        g.grant_valid  = 1'b1;
        g.granted_flow = FlowBulk;
      end
    end else if (rdy[1:0] != 2'b00) begin
      // Weighted selection; a tie goes to bulk.
      if (rdy[1:0] == 2'b11) begin
        pick_std = (standard_bytes >> regs.standard_weight_shift) <
                   (bulk_bytes >> regs.bulk_weight_shift);
      end else begin
        pick_std = rdy[1];
      end
      g.grant_valid = 1'b1;
      if (pick_std) begin
        g.granted_flow = FlowStandard;
        standard_bytes = standard_bytes + CntW'(std_len);
      end else begin
        g.granted_flow = FlowBulk;
        bulk_bytes = bulk_bytes + CntW'(bulk_len);
      end
      // Clear both counters when the weighted spread grows too large.
      wb = bulk_bytes >> regs.bulk_weight_shift;
      ws = standard_bytes >> regs.standard_weight_shift;
      hi = (wb > ws) ? wb : ws;
      lo = (wb > ws) ? ws : wb;
      if (CmpW'(hi - lo) > CmpW'(regs.starvation_limit)) begin
        bulk_bytes         = '0;
        standard_bytes     = '0;
        g.counters_cleared = 1'b1;
      end
    end
    return g;
  endfunction

  // Watch all three channels; grants are checked before new requests are queued.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    grant_t got;
    grant_t want;
    if (!rst_ni) begin
      regs.reserved_mode         = 1'b0;
      regs.starvation_limit      = 32'd1000000;
      regs.bulk_weight_shift     = 5'd0;
      regs.standard_weight_shift = 5'd1;
      bulk_bytes                 = '0;
      standard_bytes             = '0;
      expected_grants.delete();
      fails                      = 0;
      grants                     = 0;
      clears                     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegReservedMode:  regs.reserved_mode         = cfg_data_i[0];
          RegStarvLimit:    regs.starvation_limit      = cfg_data_i;
          RegBulkShift:     regs.bulk_weight_shift     = cfg_data_i[4:0];
          RegStandardShift: regs.standard_weight_shift = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (grant_valid_i && grant_ready_i) begin
        got.grant_valid      = grant_data_i[0];
        got.granted_flow     = grant_data_i[2:1];
        got.counters_cleared = grant_data_i[3];
        grants++;
        if (got.counters_cleared) begin
          clears++;
        end
        if (expected_grants.size() == 0) begin
          report($sformatf("grant beat 0x%02h with no request outstanding", grant_data_i));
        end else begin
          want = expected_grants.pop_front();
          if (got.grant_valid != want.grant_valid) begin
            report($sformatf("grant_valid %0d, predicted %0d",
                             got.grant_valid, want.grant_valid));
          end
          if (got.granted_flow != want.granted_flow) begin
            report($sformatf("granted_flow %0d, predicted %0d",
                             got.granted_flow, want.granted_flow));
          end
          if (got.counters_cleared != want.counters_cleared) begin
            report($sformatf("counters_cleared %0d, predicted %0d",
                             got.counters_cleared, want.counters_cleared));
          end
          if (grant_data_i[7:4] != 4'd0) begin
            report($sformatf("padding bits of grant beat are 0x%0h", grant_data_i[7:4]));
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        expected_grants.push_back(schedule_request(req_user_i, req_data_i[31:0],
                                                   req_data_i[63:32]));
      end
    end
    fail_count_o  <= fails;
    pending_o     <= expected_grants.size();
    grant_count_o <= grants;
    clear_count_o <= clears;
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the flow weighted priority scheduler: stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import fwps_pkg::*;

  // Generous cycle limit and the length of the long grant hold-off.
  localparam int unsigned Limit      = 200000;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned PhaseItems = 140;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid_i;
  logic               s_axis_tready_o;
  logic [63:0]        s_axis_tdata_i;
  logic [2:0]         s_axis_tuser_i;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i;
  logic [7:0]         m_axis_tdata_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [31:0]        cfg_data_i;

  int          fail_count;
  int          pending;
  int          grant_count;
  int          clear_count;
  bit          gaps_on     = 1'b0;
  bit          hold_grants = 1'b0;
  int          requests_sent;
  int          settings_used;
  int unsigned cycles;

  flow_weighted_priority_scheduler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  fwps_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid_i),
    .req_ready_i   (s_axis_tready_o),
    .req_data_i    (s_axis_tdata_i),
    .req_user_i    (s_axis_tuser_i),
    .grant_valid_i (m_axis_tvalid_o),
    .grant_ready_i (m_axis_tready_i),
    .grant_data_i  (m_axis_tdata_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .grant_count_o (grant_count),
    .clear_count_o (clear_count)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > Limit) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Grant sink: random back-pressure bursts and one long hold-off on request.
  initial begin
    m_axis_tready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_grants) begin
        hold_grants = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Offer one request beat and wait until it is taken; valid stays high after.
  task automatic push_request(input logic [2:0] rdy, input logic [31:0] bulk_len,
                              input logic [31:0] std_len);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= rdy;
    s_axis_tdata_i  <= {std_len, bulk_len};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    requests_sent++;
  endtask

  // Random idle burst on the request side.
  task automatic sender_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every predicted grant has arrived.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One register write beat; the caller lowers valid when done.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Write all four registers back to back.
  task automatic set_config(input logic mode, input logic [31:0] limit,
                            input logic [4:0] bulk_sh, input logic [4:0] std_sh);
    write_reg(RegReservedMode, {31'd0, mode});
    write_reg(RegStarvLimit, limit);
    write_reg(RegBulkShift, {27'd0, bulk_sh});
    write_reg(RegStandardShift, {27'd0, std_sh});
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Head length: mostly small, sometimes zero, all ones or fully random.
  function automatic logic [31:0] rand_len();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return '1;
      2, 3:    return $urandom();
      default: return $urandom_range(0, 4000);
    endcase
  endfunction

  // Queue mask: mostly both weighted queues contending.
  function automatic logic [2:0] rand_ready();
    if ($urandom_range(0, 9) < 6) begin
      return 3'b011;
    end
    return 3'($urandom_range(0, 7));
  endfunction

  // Main stimulus.
  initial begin : stimulus
    int p;
    int k;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    requests_sent   = 0;
    settings_used   = 0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Strict mode at reset settings: every queue mask with extreme lengths.
    for (k = 0; k < 8; k++) begin
      push_request(3'(k), (k % 2 == 0) ? 32'd0 : '1, (k % 2 == 0) ? '1 : 32'd0);
    end
    drain();

    // Reserved mode with the reset limit and shifts.
    write_reg(RegReservedMode, 32'd1);
    cfg_valid_i <= 1'b0;
    push_request(3'b011, 32'd0, 32'd0);        // tie on empty counters goes to bulk
    push_request(3'b011, 32'd100, 32'd50);
    push_request(3'b011, 32'd10, 32'd300);
    push_request(3'b001, '1, 32'd0);           // huge length wraps the bulk counter
    push_request(3'b010, 32'd0, '1);
    push_request(3'b000, '1, '1);              // nothing ready
    push_request(3'b100, '1, '1);              // urgent is never charged
    push_request(3'b111, 32'd5, 32'd5);
    push_request(3'b101, 32'd5, 32'd5);
    push_request(3'b110, 32'd5, 32'd5);
    drain();

    // Widest limit so the bulk counter wraps instead of clearing.
    set_config(1'b1, '1, 5'd0, 5'd31);
    push_request(3'b001, '1, 32'd0);
    push_request(3'b001, 32'd2, 32'd0);
    push_request(3'b011, 32'd7, 32'd7);
    drain();

    // Writes to unused indexes must not disturb anything.
    write_reg(CfgIdxW'(4), '1);
    write_reg('1, '1);
    cfg_valid_i <= 1'b0;
    push_request(3'b011, 32'd1, 32'd1);
    drain();

    // Counters survive a round trip through strict mode.
    write_reg(RegReservedMode, 32'd0);
    cfg_valid_i <= 1'b0;
    push_request(3'b011, 32'd9, 32'd9);
    drain();
    write_reg(RegReservedMode, 32'd1);
    cfg_valid_i <= 1'b0;
    push_request(3'b011, 32'd9, 32'd9);
    drain();

    // Random phases, each under its own register settings.
    for (p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: set_config(1'b1, 32'd0, 5'd0, 5'd0);
        1: set_config(1'b1, '1, 5'd31, 5'd31);
        2: set_config(1'b1, $urandom_range(1, 5000), 5'($urandom_range(0, 31)),
                      5'($urandom_range(0, 31)));
        3: set_config(1'b0, 32'd1000000, 5'd0, 5'd1);
        4: set_config(1'b1, 32'd1000000, 5'd0, 5'd1);
        5: set_config(1'b1, $urandom(), 5'($urandom_range(0, 31)),
                      5'($urandom_range(0, 31)));
        6: set_config(1'b1, $urandom_range(0, 100000), 5'd0, 5'd4);
        default: set_config(1'b1, $urandom_range(0, 20000), 5'($urandom_range(0, 8)),
                            5'($urandom_range(0, 8)));
      endcase
      // The last phase runs with no idling on either side.
      gaps_on = (p != 7);
      for (k = 0; k < PhaseItems; k++) begin
        if (p == 4 && k == 40) begin
          hold_grants = 1'b1;
        end
        if (p == 4 && k == 100) begin
          drain();
        end
        push_request(rand_ready(), rand_len(), rand_len());
        sender_gap();
      end
    end
    drain();

    $display("Covered %0d requests under %0d register settings in strict and reserved modes,",
             requests_sent, settings_used + 1);
    $display("with %0d grants checked, %0d counter clears and random back-pressure.",
             grant_count, clear_count);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== flow_weighted_priority_scheduler.f =====
src/fwps_pkg.sv
src/fwps_cfg.sv
src/fwps_sched.sv
src/flow_weighted_priority_scheduler.sv
sim/fwps_checker.sv
sim/tb.sv
